FILE: design/mmm_pkg.sv
// ----------------------------------------------------------------------------
// Moving median package
// Shared constants, types and helpers of the moving median / min / max block.
// ----------------------------------------------------------------------------
package mmm_pkg;

  // Window and sample geometry.
  localparam int MAX_WINDOW    = 32;
  localparam int SAMPLE_BITS   = 16;
  localparam int POS_BITS      = $clog2(MAX_WINDOW);
  localparam int LEN_BITS      = $clog2(MAX_WINDOW + 1);
  localparam int CFG_LEN_BITS  = 6;
  localparam int CFG_DATA_BITS = 16;
  localparam int CFG_IDX_BITS  = 2;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [POS_BITS-1:0]           pos_t;
  typedef logic [LEN_BITS-1:0]           len_t;
  typedef logic [CFG_IDX_BITS-1:0]       cfg_idx_t;
  typedef logic [CFG_DATA_BITS-1:0]      cfg_data_t;

  // Configuration register indexes.
  localparam cfg_idx_t REG_WINDOW_LENGTH = cfg_idx_t'(0);
  localparam cfg_idx_t REG_INITIAL_VALUE = cfg_idx_t'(1);

  // Reset value of the window length register.
  localparam len_t RESET_LEN = len_t'(5);

  // Controller states.
  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_FIND   = 5'b00010,
    S_COUNT  = 5'b00100,
    S_UPDATE = 5'b01000,
    S_EMIT   = 5'b10000
  } mmm_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic find;
    logic count;
    logic update;
    logic emit;
  } mmm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
  } mmm_status_t;

  // Result beat payload.
  typedef struct packed {
    sample_t median_value;
    sample_t minimum_value;
    sample_t maximum_value;
  } mmm_result_t;

  // Clamp a raw window length into the range one to MAX_WINDOW.
  function automatic len_t eff_len(logic [CFG_LEN_BITS-1:0] raw);
    len_t res;
    if (raw == '0) begin
      res = len_t'(1);
    end else if ({1'b0, raw} > (CFG_LEN_BITS+1)'(MAX_WINDOW)) begin
      res = len_t'(MAX_WINDOW);
    end else begin
      res = len_t'(raw);
    end
    return res;
  endfunction

endpackage

FILE: design/mmm_if.sv
// ----------------------------------------------------------------------------
// Moving median stream interfaces
// Valid/ready channels for the sample input and the result output.
// ----------------------------------------------------------------------------
interface mmm_in_if import mmm_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface mmm_out_if import mmm_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t median_value;
  sample_t minimum_value;
  sample_t maximum_value;

  modport source (output valid, output median_value, output minimum_value,
                  output maximum_value, input ready);
  modport sink (input valid, input median_value, input minimum_value,
                input maximum_value, output ready);
endinterface

FILE: design/moving_median_min_max_top.sv
// ----------------------------------------------------------------------------
// Moving median, minimum and maximum filter
// Keeps the last window_length samples sorted and reports median, min, max.
// ----------------------------------------------------------------------------
// Usage:
//   in_bus carries one signed sample per beat; out_bus returns one result
//   beat per sample with the median (upper median for an even length), the
//   minimum and the maximum of the current window.
//   cfg_we/cfg_index/cfg_data write window_length (index 0) or
//   initial_value (index 1); any such write refills the whole window with
//   initial_value. Write only while no sample is in flight.
// Steps:
//   A sample is taken in the idle state and its result is loaded into the
//   output register after the steps below; no new sample is taken until then.
//   The steps are: locate the oldest entry and compare all cells, count
//   the new position, shift the cells, load the output register.
// Reset and stall:
//   After reset the window length is five and every entry holds zero.
//   The result sits in an output register; if the receiver stalls, the
//   next sample is still taken and processed, and it waits in its last step
//   until the output register is taken.
// ----------------------------------------------------------------------------
module moving_median_min_max_top import mmm_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  cfg_idx_t      cfg_index,
  input  cfg_data_t     cfg_data,
  mmm_in_if.sink        in_bus,
  mmm_out_if.source     out_bus
);

  mmm_cmd_t    cmd;
  mmm_status_t status;
  mmm_result_t result;

  // Item sequencing.
  mmm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_bus.valid),
    .in_ready (in_bus.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Window storage and result register.
  mmm_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_sample (in_bus.sample),
    .out_ready (out_bus.ready),
    .out_valid (out_bus.valid),
    .result    (result)
  );

  // Result beat fields.
  assign out_bus.median_value  = result.median_value;
  assign out_bus.minimum_value = result.minimum_value;
  assign out_bus.maximum_value = result.maximum_value;

endmodule

FILE: design/mmm_ctrl.sv
// ----------------------------------------------------------------------------
// Moving median controller
// Sequences one sample through find, count, update and emit steps.
// ----------------------------------------------------------------------------
module mmm_ctrl import mmm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  mmm_status_t status,
  output mmm_cmd_t    cmd
);

  mmm_state_t state_r, state_nxt;

  // A new sample is taken only between items.
  assign in_ready = (state_r == S_IDLE);

  // Next state and command decode.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_FIND;
        end
      end
      S_FIND: begin
        cmd.find  = 1'b1;
        state_nxt = S_COUNT;
      end
      S_COUNT: begin
        cmd.count = 1'b1;
        state_nxt = S_UPDATE;
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = S_EMIT;
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: design/mmm_datapath.sv
// ----------------------------------------------------------------------------
// Moving median datapath
// Sorted window cells, ring slot tracking, configuration and result register.
// ----------------------------------------------------------------------------
module mmm_datapath import mmm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  mmm_cmd_t    cmd,
  output mmm_status_t status,
  input  logic        cfg_we,
  input  cfg_idx_t    cfg_index,
  input  cfg_data_t   cfg_data,
  input  sample_t     in_sample,
  input  logic        out_ready,
  output logic        out_valid,
  output mmm_result_t result
);

  // Configuration and window state.
  len_t        len_r;
  sample_t     init_r;
  pos_t        oldest_r;
  sample_t     vals_r [MAX_WINDOW];
  pos_t        orig_r [MAX_WINDOW];
  sample_t     vals_nxt [MAX_WINDOW];
  pos_t        orig_nxt [MAX_WINDOW];

  // Per-item working registers.
  sample_t     x_r;
  pos_t        slot_r;
  pos_t        p_r, p_nxt;
  pos_t        k_r, k_nxt;
  logic [MAX_WINDOW-1:0] le_r, lt_r, le_nxt, lt_nxt, sel;

  // Output register.
  logic        out_valid_r;
  mmm_result_t result_r;

  // Configuration write decode.
  logic        cfg_hit;
  len_t        len_new;
  sample_t     init_new;

  assign cfg_hit  = cfg_we && ((cfg_index == REG_WINDOW_LENGTH) ||
                               (cfg_index == REG_INITIAL_VALUE));
  assign len_new  = (cfg_index == REG_WINDOW_LENGTH) ?
                    eff_len(cfg_data[CFG_LEN_BITS-1:0]) : len_r;
  assign init_new = (cfg_index == REG_INITIAL_VALUE) ?
                    sample_t'(cfg_data[SAMPLE_BITS-1:0]) : init_r;

  // Locate the oldest slot's entry and compare every cell with the new sample.
  always_comb begin
    p_nxt = '0;
    for (int j = 0; j < MAX_WINDOW; j++) begin
      if (orig_r[j] == slot_r) begin
        p_nxt = p_nxt | pos_t'(j);
      end
      le_nxt[j] = (vals_r[j] <= x_r);
      lt_nxt[j] = (vals_r[j] < x_r);
    end
  end

  // Final position: cells left of the old entry that are not greater, plus
  // cells right of it that are strictly smaller, so equal values keep order.
  always_comb begin
    for (int j = 0; j < MAX_WINDOW; j++) begin
      sel[j] = (len_t'(j) < len_r) &&
               (((pos_t'(j) < p_r) && le_r[j]) || ((pos_t'(j) > p_r) && lt_r[j]));
    end
    k_nxt = pos_t'($countones(sel));
  end

  // Each cell takes its own value, a neighbor's, or the new sample.
  for (genvar j = 0; j < MAX_WINDOW; j++) begin : g_cell
    localparam pos_t J = pos_t'(j);
    sample_t from_right, from_left;
    pos_t    org_right, org_left;

    if (j < MAX_WINDOW - 1) begin : g_right
      assign from_right = vals_r[j+1];
      assign org_right  = orig_r[j+1];
    end else begin : g_no_right
      assign from_right = vals_r[j];
      assign org_right  = orig_r[j];
    end

    if (j > 0) begin : g_left
      assign from_left = vals_r[j-1];
      assign org_left  = orig_r[j-1];
    end else begin : g_no_left
      assign from_left = vals_r[j];
      assign org_left  = orig_r[j];
    end

    always_comb begin
      vals_nxt[j] = vals_r[j];
      orig_nxt[j] = orig_r[j];
      if (J == k_r) begin
        vals_nxt[j] = x_r;
        orig_nxt[j] = slot_r;
      end else if ((p_r <= k_r) && (J >= p_r) && (J < k_r)) begin
        vals_nxt[j] = from_right;
        orig_nxt[j] = org_right;
      end else if ((k_r < p_r) && (J > k_r) && (J <= p_r)) begin
        vals_nxt[j] = from_left;
        orig_nxt[j] = org_left;
      end
    end
  end

  // Window, configuration and control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= RESET_LEN;
      init_r      <= '0;
      oldest_r    <= pos_t'(RESET_LEN - len_t'(1));
      out_valid_r <= 1'b0;
      for (int j = 0; j < MAX_WINDOW; j++) begin
        vals_r[j] <= '0;
        orig_r[j] <= pos_t'(j);
      end
    end else begin
      if (cfg_hit) begin
        len_r    <= len_new;
        init_r   <= init_new;
        oldest_r <= pos_t'(len_new - len_t'(1));
        for (int j = 0; j < MAX_WINDOW; j++) begin
          vals_r[j] <= init_new;
          orig_r[j] <= pos_t'(j);
        end
      end else begin
        if (cmd.accept) begin
          oldest_r <= (oldest_r == '0) ? pos_t'(len_r - len_t'(1))
                                       : oldest_r - pos_t'(1);
        end
        if (cmd.update) begin
          vals_r <= vals_nxt;
          orig_r <= orig_nxt;
        end
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Working and result payload registers.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      x_r    <= in_sample;
      slot_r <= oldest_r;
    end
    if (cmd.find) begin
      p_r  <= p_nxt;
      le_r <= le_nxt;
      lt_r <= lt_nxt;
    end
    if (cmd.count) begin
      k_r <= k_nxt;
    end
    if (cmd.emit) begin
      result_r.median_value  <= vals_r[pos_t'(len_r >> 1)];
      result_r.minimum_value <= vals_r[0];
      result_r.maximum_value <= vals_r[pos_t'(len_r - len_t'(1))];
    end
  end

  assign status.out_free = !out_valid_r || out_ready;
  assign out_valid       = out_valid_r;
  assign result          = result_r;

endmodule

FILE: tb/moving_median_min_max_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Moving median / min / max filter testbench
// Streams signed samples through the filter under several window lengths and
// fill values, predicts every result beat with a sorted-window model kept
// here, and compares median, minimum and maximum of each beat as it leaves.
// ----------------------------------------------------------------------------
module moving_median_min_max_top_tb import mmm_pkg::*; ();

  localparam int IDLE_LIMIT    = 2000;
  localparam int SETTLE_CYCLES = 12;

  // Register indexes past the end of the register list; writes are ignored.
  localparam cfg_idx_t REG_SPARE_A = cfg_idx_t'(2);
  localparam cfg_idx_t REG_SPARE_B = cfg_idx_t'(3);

  typedef enum int {
    PAT_FULL,
    PAT_NARROW,
    PAT_RAMP_UP,
    PAT_RAMP_DOWN,
    PAT_EXTREME
  } pattern_t;

  logic      clk;
  logic      rst_n;
  logic      cfg_we;
  cfg_idx_t  cfg_index;
  cfg_data_t cfg_data;

  mmm_in_if  in_bus ();
  mmm_out_if out_bus ();

  moving_median_min_max_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_bus    (in_bus),
    .out_bus   (out_bus)
  );

  // Sorted window model: values in ascending order, the ring slot each
  // entry came from, and the sorted position of each ring slot.
  sample_t     win_value [MAX_WINDOW];
  int          win_slot [MAX_WINDOW];
  int          slot_pos [MAX_WINDOW];
  int          oldest_slot_m;
  int          win_len;
  logic [5:0]  len_reg;
  sample_t     init_reg;
  mmm_result_t expected_results [$];

  int      errors = 0;
  int      idle_cycles = 0;
  bit      in_gaps;
  bit      out_stalls;
  sample_t ramp_value;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Refill the model window, as the block does at reset and on a write.
  function void refill_window();
    int i;
    if (len_reg == 6'd0) begin
      win_len = 1;
    end else if (int'(len_reg) > MAX_WINDOW) begin
      win_len = MAX_WINDOW;
    end else begin
      win_len = int'(len_reg);
    end
    for (i = 0; i < MAX_WINDOW; i++) begin
      win_value[i] = init_reg;
      win_slot[i]  = i;
      slot_pos[i]  = i;
    end
    oldest_slot_m = win_len - 1;
  endfunction

  function void swap_entries(int a, int b);
    sample_t v;
    int      s;
    v            = win_value[a];
    s            = win_slot[a];
    win_value[a] = win_value[b];
    win_slot[a]  = win_slot[b];
    win_value[b] = v;
    win_slot[b]  = s;
    slot_pos[win_slot[a]] = a;
    slot_pos[win_slot[b]] = b;
  endfunction

  // Replace the oldest sample, move it into order and queue the result.
  function void predict_window(sample_t s);
    int          slot;
    int          p;
    mmm_result_t r;
    slot = oldest_slot_m;
    p    = slot_pos[slot];
    win_value[p]  = s;
    oldest_slot_m = (slot == 0) ? win_len - 1 : slot - 1;
    while (p + 1 < win_len && win_value[p] > win_value[p + 1]) begin
      swap_entries(p, p + 1);
      p++;
    end
    while (p > 0 && win_value[p] < win_value[p - 1]) begin
      swap_entries(p, p - 1);
      p--;
    end
    r.median_value  = win_value[win_len / 2];
    r.minimum_value = win_value[0];
    r.maximum_value = win_value[win_len - 1];
    expected_results.push_back(r);
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function sample_t next_sample(pattern_t pat);
    sample_t d;
    case (pat)
      PAT_NARROW: begin
        // Values close to the fill value give many equal entries.
        d = sample_t'($urandom_range(0, 6));
        return init_reg + d - sample_t'(3);
      end
      PAT_RAMP_UP: begin
        ramp_value = ramp_value + sample_t'($urandom_range(1, 300));
        return ramp_value;
      end
      PAT_RAMP_DOWN: begin
        ramp_value = ramp_value - sample_t'($urandom_range(1, 300));
        return ramp_value;
      end
      PAT_EXTREME: begin
        case ($urandom_range(0, 3))
          0: return sample_t'(16'sh8000);
          1: return sample_t'(16'sh7FFF);
          2: return init_reg;
          default: return sample_t'(0);
        endcase
      end
      default: return sample_t'($urandom);
    endcase
  endfunction

  task automatic log_mismatch(string field, sample_t got, sample_t want);
    $display("mismatch on %s: got %0d, expected %0d at %0t", field, got, want, $realtime);
    errors++;
  endtask

  // Send one sample beat; the model is updated when the beat is taken.
  task automatic send_sample(sample_t s);
    int gap;
    gap = in_gaps ? pick_gap() : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_bus.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_bus.valid  = 1'b1;
    in_bus.sample = s;
    do @(posedge clk); while (!in_bus.ready);
    predict_window(s);
  endtask

  task automatic stop_stream();
    @(negedge clk);
    in_bus.valid = 1'b0;
  endtask

  task automatic run_burst(int count, pattern_t pat);
    int i;
    ramp_value = sample_t'($urandom);
    for (i = 0; i < count; i++) begin
      send_sample(next_sample(pat));
    end
  endtask

  // Write a register once the block has drained, and mirror it in the model.
  task automatic write_register(cfg_idx_t idx, cfg_data_t data);
    stop_stream();
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_WINDOW_LENGTH: begin
        len_reg = data[5:0];
        refill_window();
      end
      REG_INITIAL_VALUE: begin
        init_reg = sample_t'(data);
        refill_window();
      end
      default: ;
    endcase
  endtask

  function automatic cfg_data_t length_word(logic [5:0] len);
    return {10'($urandom), len};
  endfunction

  // Default window after reset: extremes and repeated values.
  task automatic test_reset_window();
    in_gaps    = 1'b1;
    out_stalls = 1'b1;
    send_sample(sample_t'(16'sh7FFF));
    send_sample(sample_t'(16'sh8000));
    send_sample(sample_t'(16'sh8000));
    send_sample(sample_t'(16'sh7FFF));
    send_sample(sample_t'(0));
    send_sample(sample_t'(-1));
    send_sample(sample_t'(1));
    send_sample(sample_t'(1));
  endtask

  // Zero, full, saturated and even window lengths with extreme fill values.
  task automatic test_length_limits();
    write_register(REG_WINDOW_LENGTH, cfg_data_t'(16'hFFC0));
    send_sample(sample_t'(16'sh7FFF));
    send_sample(sample_t'(16'sh8000));
    send_sample(sample_t'(5));

    write_register(REG_INITIAL_VALUE, cfg_data_t'(16'h8000));
    write_register(REG_WINDOW_LENGTH, cfg_data_t'(16'h0020));
    send_sample(sample_t'(16'sh7FFF));
    send_sample(sample_t'(16'sh8000));
    send_sample(sample_t'(16'sh7FFF));
    send_sample(sample_t'(-2));

    write_register(REG_INITIAL_VALUE, cfg_data_t'(16'h7FFF));
    write_register(REG_WINDOW_LENGTH, cfg_data_t'(16'h003F));
    send_sample(sample_t'(16'sh8000));
    send_sample(sample_t'(16'sh7FFF));
    send_sample(sample_t'(0));

    write_register(REG_WINDOW_LENGTH, cfg_data_t'(16'h0002));
    send_sample(sample_t'(16'sh8000));
    send_sample(sample_t'(3));
    send_sample(sample_t'(3));
  endtask

  // Writes to unused indexes must leave the window untouched.
  task automatic test_spare_indexes();
    write_register(REG_WINDOW_LENGTH, length_word(6'd9));
    run_burst(6, PAT_FULL);
    write_register(REG_SPARE_A, cfg_data_t'($urandom));
    run_burst(6, PAT_FULL);
    write_register(REG_SPARE_B, cfg_data_t'($urandom));
    run_burst(6, PAT_NARROW);
  endtask

  // Random lengths, fill values and sample shapes, with varied idling.
  task automatic test_random_phases();
    int         ph;
    logic [5:0] len;
    pattern_t   pat;
    for (ph = 0; ph < 14; ph++) begin
      case ($urandom_range(0, 7))
        0: len = 6'd0;
        1: len = 6'd1;
        2: len = 6'd32;
        3: len = 6'($urandom_range(33, 63));
        4: len = 6'($urandom_range(2, 4));
        default: len = 6'($urandom_range(1, 32));
      endcase
      if ($urandom_range(0, 1) == 0) begin
        write_register(REG_INITIAL_VALUE, cfg_data_t'($urandom));
        write_register(REG_WINDOW_LENGTH, length_word(len));
      end else begin
        write_register(REG_WINDOW_LENGTH, length_word(len));
        write_register(REG_INITIAL_VALUE, cfg_data_t'($urandom));
      end
      in_gaps    = ($urandom_range(0, 3) != 0);
      out_stalls = ($urandom_range(0, 3) != 0);
      pat        = pattern_t'($urandom_range(0, 4));
      run_burst(128, pat);
    end
  endtask

  // Full rate on both sides, then stalls on the result side only.
  task automatic test_back_to_back();
    in_gaps    = 1'b0;
    out_stalls = 1'b0;
    write_register(REG_WINDOW_LENGTH, length_word(6'd7));
    run_burst(40, PAT_FULL);
    out_stalls = 1'b1;
    run_burst(40, PAT_NARROW);
  endtask

  // Result side: random stalls on ready.
  initial begin
    forever begin
      @(negedge clk);
      if (out_stalls && $urandom_range(0, 3) == 0) begin
        out_bus.ready = 1'b0;
        repeat (pick_gap()) @(negedge clk);
      end else begin
        out_bus.ready = 1'b1;
      end
    end
  end

  // Compare each result beat with the oldest expectation.
  always @(posedge clk) begin : result_check
    mmm_result_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (expected_results.size() == 0) begin
        log_mismatch("unexpected beat (median)", out_bus.median_value, sample_t'(0));
      end else begin
        want = expected_results.pop_front();
        if (out_bus.median_value !== want.median_value)
          log_mismatch("median_value", out_bus.median_value, want.median_value);
        if (out_bus.minimum_value !== want.minimum_value)
          log_mismatch("minimum_value", out_bus.minimum_value, want.minimum_value);
        if (out_bus.maximum_value !== want.maximum_value)
          log_mismatch("maximum_value", out_bus.maximum_value, want.maximum_value);
      end
    end
  end

  // Watchdog: end the run if no beat moves for too long.
  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no beat for %0d cycles", IDLE_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = REG_WINDOW_LENGTH;
    cfg_data      = '0;
    in_bus.valid  = 1'b0;
    in_bus.sample = '0;
    out_bus.ready = 1'b0;
    in_gaps       = 1'b1;
    out_stalls    = 1'b1;
    ramp_value    = '0;
    len_reg       = 6'd5;
    init_reg      = '0;
    refill_window();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_window();
    test_length_limits();
    test_spare_indexes();
    test_random_phases();
    test_back_to_back();

    // Drain the remaining results, then allow for any stray beat.
    stop_stream();
    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
